// ===== rtl/brb_pkg.sv =====
package brb_pkg;

   // fixed field widths of the request and response beats
   localparam int LEN_W  = 4;
   localparam int BYTE_W = 8;
   localparam int DATA_W = 64;

   // default sizing, handed to the top level parameters
   localparam int DEF_BUF_DEPTH = 256;
   localparam int DEF_MAX_BURST = 8;

   // request kinds
   localparam logic REQ_PUSH = 1'b0;
   localparam logic REQ_POP  = 1'b1;

   // per-cycle control of the byte store port
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } store_ctl_type;

endpackage

// ===== rtl/brb_lane.sv =====
module brb_lane import brb_pkg::*; #(
   parameter int BUF_DEPTH = DEF_BUF_DEPTH,
   parameter int LANE_IDX  = 0,
   localparam int PTR_W    = $clog2(BUF_DEPTH)
) (
   input  logic              clock,
   input  logic              load,
   input  logic [PTR_W-1:0]  base_ptr,
   input  logic [DATA_W-1:0] data_bytes,
   output logic [PTR_W-1:0]  lane_addr,
   output logic [BYTE_W-1:0] lane_byte
);

   logic [PTR_W-1:0]  addr_ff, addr_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic [PTR_W:0]    addr_sum;

   // ring address of this burst position, wrapped at the buffer depth
   always_comb begin
      addr_sum = {1'b0, base_ptr} + (PTR_W+1)'(LANE_IDX);
      if (addr_sum >= (PTR_W+1)'(BUF_DEPTH)) begin
         addr_sum = addr_sum - (PTR_W+1)'(BUF_DEPTH);
      end
      addr_in = addr_sum[PTR_W-1:0];
      byte_in = data_bytes[LANE_IDX*BYTE_W +: BYTE_W];
   end

   // capture address and push byte when a request is taken
   always_ff @(posedge clock) begin
      if (load) begin
         addr_ff <= addr_in;
         byte_ff <= byte_in;
      end
   end

   assign lane_addr = addr_ff;
   assign lane_byte = byte_ff;

endmodule

// ===== rtl/brb_store.sv =====
module brb_store import brb_pkg::*; #(
   parameter int BUF_DEPTH = DEF_BUF_DEPTH,
   localparam int PTR_W    = $clog2(BUF_DEPTH)
) (
   input  logic              clock,
   input  store_ctl_type     ctl,
   input  logic [PTR_W-1:0]  addr,
   input  logic [BYTE_W-1:0] wr_data,
   output logic [BYTE_W-1:0] rd_data
);

   logic [BYTE_W-1:0] mem [BUF_DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   // single port: one write or one registered read per cycle
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/byte_ring_buffer_burst_unit.sv =====
// Circular byte FIFO with all-or-nothing push and pop bursts.
// Request channel: a beat is taken when start is high and busy is low.
//   req_type selects push or pop, req_burst_len gives 1..MAX_BURST bytes,
//   req_data_bytes carries push bytes packed, byte 0 in the low bits.
// Response channel: each beat is valid for one cycle with rsp_strobe high;
//   the receiver cannot stall, so every beat must be captured when shown.
// A refused request (zero or oversize length, push beyond free space, pop
//   beyond fill count) gives one beat in the cycle after the request, with
//   rsp_accepted_len zero and rsp_is_last set.
// A push writes one byte per cycle through the single-port byte store;
//   its one beat follows the last write.
// A pop reads one byte per cycle; beats appear on consecutive cycles once
//   the registered store read returns, len beats in all, the last one marked.
// busy drops during the final beat of a push or pop, so a new request can be
//   taken while that beat is shown; a refused request never raises busy.
// rsp_free_space always shows the free bytes after the current request.
// Reset empties the buffer (pointers and fill count cleared); the store
//   itself is not cleared, since only written bytes are ever read.
module byte_ring_buffer_burst_unit import brb_pkg::*; #(
   parameter int BUF_DEPTH = DEF_BUF_DEPTH,
   parameter int MAX_BURST = DEF_MAX_BURST,
   localparam int PTR_W    = $clog2(BUF_DEPTH),
   localparam int CNT_W    = $clog2(BUF_DEPTH + 1),
   localparam int STEP_W   = (MAX_BURST > 1) ? $clog2(MAX_BURST) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic              req_type,
   input  logic [LEN_W-1:0]  req_burst_len,
   input  logic [DATA_W-1:0] req_data_bytes,
   output logic              rsp_strobe,
   output logic [LEN_W-1:0]  rsp_accepted_len,
   output logic [BYTE_W-1:0] rsp_out_byte,
   output logic              rsp_is_last,
   output logic [CNT_W-1:0]  rsp_free_space
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_PUSH = 3'b010,
      ST_POP  = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [PTR_W-1:0]  wptr_ff, wptr_in;
   logic [PTR_W-1:0]  rptr_ff, rptr_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_pop_ff, rsp_pop_in;
   logic [LEN_W-1:0]  rsp_len_ff, rsp_len_in;

   logic              accept;
   logic              len_ok;
   logic              fit_ok;
   logic              go;
   logic              step_last;
   logic [CNT_W-1:0]  free_cnt;
   logic [PTR_W-1:0]  base_ptr;
   logic [PTR_W:0]    ptr_sum;
   logic [PTR_W-1:0]  ptr_next;
   logic [PTR_W-1:0]  lane_addr [MAX_BURST];
   logic [BYTE_W-1:0] lane_byte [MAX_BURST];
   logic [PTR_W-1:0]  sel_addr;
   logic [BYTE_W-1:0] sel_byte;
   logic [BYTE_W-1:0] rd_data;
   store_ctl_type     store_ctl;

   assign busy     = (state_ff != ST_IDLE);
   assign accept   = start && !busy;
   assign free_cnt = CNT_W'(BUF_DEPTH) - fill_ff;

   // admission check: whole burst or nothing
   always_comb begin
      len_ok = (req_burst_len != '0) && (req_burst_len <= LEN_W'(MAX_BURST));
      if (req_type == REQ_POP) begin
         fit_ok = CNT_W'(req_burst_len) <= fill_ff;
      end else begin
         fit_ok = CNT_W'(req_burst_len) <= free_cnt;
      end
      go = accept && len_ok && fit_ok;
   end

   // burst start pointer and its advance past the burst
   always_comb begin
      base_ptr = (req_type == REQ_POP) ? rptr_ff : wptr_ff;
      ptr_sum  = {1'b0, base_ptr} + (PTR_W+1)'(req_burst_len);
      if (ptr_sum >= (PTR_W+1)'(BUF_DEPTH)) begin
         ptr_sum = ptr_sum - (PTR_W+1)'(BUF_DEPTH);
      end
      ptr_next = ptr_sum[PTR_W-1:0];
   end

   // one lane per burst position: address and byte set up in parallel
   for (genvar gi = 0; gi < MAX_BURST; gi++) begin : g_lane
      brb_lane #(
         .BUF_DEPTH (BUF_DEPTH),
         .LANE_IDX  (gi)
      ) u_lane (
         .clock      (clock),
         .load       (accept),
         .base_ptr   (base_ptr),
         .data_bytes (req_data_bytes),
         .lane_addr  (lane_addr[gi]),
         .lane_byte  (lane_byte[gi])
      );
   end

   // merge: walk the lanes in burst order onto the store port
   assign sel_addr  = lane_addr[step_ff];
   assign sel_byte  = lane_byte[step_ff];
   assign step_last = (LEN_W'(step_ff) + LEN_W'(1)) == len_ff;

   always_comb begin
      store_ctl.wr_en = (state_ff == ST_PUSH);
      store_ctl.rd_en = (state_ff == ST_POP);
   end

   brb_store #(
      .BUF_DEPTH (BUF_DEPTH)
   ) u_store (
      .clock   (clock),
      .ctl     (store_ctl),
      .addr    (sel_addr),
      .wr_data (sel_byte),
      .rd_data (rd_data)
   );

   // sequencer and response beat generation
   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      fill_in       = fill_ff;
      wptr_in       = wptr_ff;
      rptr_in       = rptr_ff;
      len_in        = len_ff;
      rsp_strobe_in = 1'b0;
      rsp_last_in   = rsp_last_ff;
      rsp_pop_in    = rsp_pop_ff;
      rsp_len_in    = rsp_len_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               len_in  = req_burst_len;
               step_in = '0;
               if (go) begin
                  if (req_type == REQ_POP) begin
                     state_in = ST_POP;
                     fill_in  = fill_ff - CNT_W'(req_burst_len);
                     rptr_in  = ptr_next;
                  end else begin
                     state_in = ST_PUSH;
                     fill_in  = fill_ff + CNT_W'(req_burst_len);
                     wptr_in  = ptr_next;
                  end
               end else begin
                  rsp_strobe_in = 1'b1;
                  rsp_len_in    = '0;
                  rsp_last_in   = 1'b1;
                  rsp_pop_in    = 1'b0;
               end
            end
         end
         ST_PUSH: begin
            step_in = step_ff + STEP_W'(1);
            if (step_last) begin
               state_in      = ST_IDLE;
               rsp_strobe_in = 1'b1;
               rsp_len_in    = len_ff;
               rsp_last_in   = 1'b1;
               rsp_pop_in    = 1'b0;
            end
         end
         ST_POP: begin
            step_in       = step_ff + STEP_W'(1);
            rsp_strobe_in = 1'b1;
            rsp_len_in    = len_ff;
            rsp_last_in   = step_last;
            rsp_pop_in    = 1'b1;
            if (step_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         fill_ff       <= '0;
         wptr_ff       <= '0;
         rptr_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         wptr_ff       <= wptr_in;
         rptr_ff       <= rptr_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // burst bookkeeping and response payload
   always_ff @(posedge clock) begin
      step_ff     <= step_in;
      len_ff      <= len_in;
      rsp_last_ff <= rsp_last_in;
      rsp_pop_ff  <= rsp_pop_in;
      rsp_len_ff  <= rsp_len_in;
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_accepted_len = rsp_len_ff;
   assign rsp_is_last      = rsp_last_ff;
   assign rsp_out_byte     = rsp_pop_ff ? rd_data : '0;
   assign rsp_free_space   = free_cnt;

   // fill count never exceeds the ring depth
   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(BUF_DEPTH))
      else $error("fill count above buffer depth");

   // a taken request always leads to work or a beat in the next cycle
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      accept |=> (busy || rsp_strobe))
      else $error("request taken but nothing followed");

   // a refused request is a single, final beat
   a_refuse_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_accepted_len == '0)) |-> rsp_is_last)
      else $error("refused beat not marked last");

   // pop beats come back to back until the last one
   a_pop_contig: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_is_last) |=> rsp_strobe)
      else $error("gap inside pop burst");

   // a push writes the store only while the buffer has room for it
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_type == REQ_PUSH) && go) |=> (fill_ff <= CNT_W'(BUF_DEPTH)))
      else $error("push overfilled buffer");

endmodule

// ===== dv/tb_byte_ring_buffer_burst_unit.sv =====
`timescale 1ns / 100ps

module tb_byte_ring_buffer_burst_unit;
   import brb_pkg::*;

   localparam int DEPTH       = DEF_BUF_DEPTH;
   localparam int BURST_MAX   = DEF_MAX_BURST;
   localparam int SPACE_W     = $clog2(DEPTH + 1);
   localparam int PTR_W       = $clog2(DEPTH);
   localparam int N_RANDOM    = 380;
   localparam int TAIL_CYCLES = 40;
   localparam int CYCLE_LIMIT = 300000;
   localparam int N_ROWS      = 19;

   // one response beat as seen on the rsp_ ports
   typedef struct {
      logic [LEN_W-1:0]   acc_len;
      logic [BYTE_W-1:0]  data_byte;
      logic               last;
      logic [SPACE_W-1:0] space;
   } beat_type;

   // directed row; when typed, the response is given here instead of predicted
   typedef struct {
      logic               kind;
      logic [LEN_W-1:0]   len;
      logic [DATA_W-1:0]  data;
      bit                 typed;
      logic [LEN_W-1:0]   exp_len;
      logic [SPACE_W-1:0] exp_space;
   } dir_row_type;

   logic               clock          = 1'b0;
   logic               reset          = 1'b1;
   logic               start          = 1'b0;
   logic               req_type       = REQ_PUSH;
   logic [LEN_W-1:0]   req_burst_len  = '0;
   logic [DATA_W-1:0]  req_data_bytes = '0;
   logic               busy;
   logic               rsp_strobe;
   logic [LEN_W-1:0]   rsp_accepted_len;
   logic [BYTE_W-1:0]  rsp_out_byte;
   logic               rsp_is_last;
   logic [SPACE_W-1:0] rsp_free_space;

   // mirror of the ring
   logic [BYTE_W-1:0]  ring_bytes [DEPTH];
   logic [PTR_W-1:0]   ring_wr   = '0;
   logic [PTR_W-1:0]   ring_rd   = '0;
   logic [SPACE_W-1:0] ring_fill = '0;
   beat_type           step_beats [BURST_MAX];
   int                 step_count;

   beat_type due_beats [$];
   int       fail_count  = 0;
   int       cycle_count = 0;

   dir_row_type dir_rows [N_ROWS] = '{
      // pop on empty, zero and oversize lengths on both sides
      '{REQ_POP,  4'd1,  64'h0,                  1'b1, 4'd0, 9'd256},
      '{REQ_PUSH, 4'd0,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 4'd0, 9'd256},
      '{REQ_PUSH, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 4'd0, 9'd256},
      '{REQ_PUSH, 4'd9,  64'h1234_5678_9ABC_DEF0, 1'b1, 4'd0, 9'd256},
      '{REQ_POP,  4'd0,  64'h0,                  1'b1, 4'd0, 9'd256},
      '{REQ_POP,  4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 4'd0, 9'd256},
      // pushes with all-ones, all-zero and mixed bytes, then pops with an oversize one
      '{REQ_PUSH, 4'd8,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 4'd8, 9'd248},
      '{REQ_PUSH, 4'd1,  64'h0,                  1'b1, 4'd1, 9'd247},
      '{REQ_PUSH, 4'd8,  64'h0123_4567_89AB_CDEF, 1'b1, 4'd8, 9'd239},
      '{REQ_POP,  4'd8,  64'h0,                  1'b0, 4'd0, 9'd0},
      '{REQ_POP,  4'd9,  64'h0,                  1'b1, 4'd0, 9'd247},
      '{REQ_POP,  4'd2,  64'h0,                  1'b0, 4'd0, 9'd0},
      // pop longer than fill count, then refill, drain and pop on empty
      '{REQ_POP,  4'd8,  64'h0,                  1'b1, 4'd0, 9'd249},
      '{REQ_PUSH, 4'd8,  64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 4'd8, 9'd241},
      '{REQ_POP,  4'd7,  64'h0,                  1'b0, 4'd0, 9'd0},
      '{REQ_POP,  4'd8,  64'h0,                  1'b0, 4'd0, 9'd0},
      '{REQ_POP,  4'd1,  64'h0,                  1'b1, 4'd0, 9'd256},
      '{REQ_PUSH, 4'd3,  64'h5555_5555_5555_5555, 1'b1, 4'd3, 9'd253},
      '{REQ_POP,  4'd3,  64'h0,                  1'b0, 4'd0, 9'd0}
   };

   byte_ring_buffer_burst_unit #(
      .BUF_DEPTH (DEPTH),
      .MAX_BURST (BURST_MAX)
   ) DUT (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_type         (req_type),
      .req_burst_len    (req_burst_len),
      .req_data_bytes   (req_data_bytes),
      .rsp_strobe       (rsp_strobe),
      .rsp_accepted_len (rsp_accepted_len),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_is_last      (rsp_is_last),
      .rsp_free_space   (rsp_free_space)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ring mirror: applies one request, leaves its beats in step_beats
   function automatic void ring_step(input logic kind, input logic [LEN_W-1:0] len,
                                     input logic [DATA_W-1:0] data);
      int i;
      int room;
      step_count = 0;
      room = (kind == REQ_PUSH) ? DEPTH - int'(ring_fill) : int'(ring_fill);
      if (len == 0 || len > BURST_MAX || len > room) begin
         // refused whole: single beat, nothing moves
         step_beats[0] = '{LEN_W'(0), BYTE_W'(0), 1'b1, SPACE_W'(DEPTH) - ring_fill};
         step_count = 1;
      end else if (kind == REQ_PUSH) begin
         for (i = 0; i < len; i++) begin
            ring_bytes[ring_wr] = data[8*i +: 8];
            ring_wr = (ring_wr == PTR_W'(DEPTH - 1)) ? '0 : ring_wr + 1'b1;
         end
         ring_fill = ring_fill + len;
         step_beats[0] = '{len, BYTE_W'(0), 1'b1, SPACE_W'(DEPTH) - ring_fill};
         step_count = 1;
      end else begin
         // fill drops before the beats go out, so all show the final space
         ring_fill = ring_fill - len;
         for (i = 0; i < len; i++) begin
            step_beats[i] = '{len, ring_bytes[ring_rd], (i == len - 1),
                              SPACE_W'(DEPTH) - ring_fill};
            ring_rd = (ring_rd == PTR_W'(DEPTH - 1)) ? '0 : ring_rd + 1'b1;
         end
         step_count = int'(len);
      end
   endfunction

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   // drive one request beat, wait for the handshake, then queue what is due
   task automatic send_request(input logic kind, input logic [LEN_W-1:0] len,
                               input logic [DATA_W-1:0] data, input int gap,
                               input bit typed, input logic [LEN_W-1:0] t_len,
                               input logic [SPACE_W-1:0] t_space);
      int i;
      if (gap > 0) begin
         @(negedge clock);
         start          <= 1'b0;
         req_type       <= 1'($urandom_range(1));
         req_burst_len  <= LEN_W'($urandom_range(15));
         req_data_bytes <= {$urandom, $urandom};
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start          <= 1'b1;
      req_type       <= kind;
      req_burst_len  <= len;
      req_data_bytes <= data;
      do @(posedge clock); while (busy);
      ring_step(kind, len, data);
      if (typed)
         due_beats.push_back('{t_len, BYTE_W'(0), 1'b1, t_space});
      else
         for (i = 0; i < step_count; i++) due_beats.push_back(step_beats[i]);
   endtask

   // response check against the oldest due beat
   always @(posedge clock) begin : check_beat
      beat_type want;
      if (!reset && rsp_strobe) begin
         if (due_beats.size() == 0) begin
            $error("unexpected beat: accepted_len %0d out_byte %0h is_last %0d free_space %0d",
                   rsp_accepted_len, rsp_out_byte, rsp_is_last, rsp_free_space);
            fail_count++;
         end else begin
            want = due_beats.pop_front();
            if (rsp_accepted_len !== want.acc_len) begin
               $error("accepted_len: expected %0d, got %0d", want.acc_len, rsp_accepted_len);
               fail_count++;
            end
            if (rsp_out_byte !== want.data_byte) begin
               $error("out_byte: expected %0h, got %0h", want.data_byte, rsp_out_byte);
               fail_count++;
            end
            if (rsp_is_last !== want.last) begin
               $error("is_last: expected %0d, got %0d", want.last, rsp_is_last);
               fail_count++;
            end
            if (rsp_free_space !== want.space) begin
               $error("free_space: expected %0d, got %0d", want.space, rsp_free_space);
               fail_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin : stimulus
      int               n;
      int               roll;
      int               room;
      int               gap;
      bit               filling;
      logic             kind;
      logic [LEN_W-1:0] len;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table
      for (n = 0; n < N_ROWS; n++)
         send_request(dir_rows[n].kind, dir_rows[n].len, dir_rows[n].data, pick_gap(),
                      dir_rows[n].typed, dir_rows[n].exp_len, dir_rows[n].exp_space);

      // random part: sweep the ring from empty to full and back, which
      // wraps both pointers several times; a share of beats is noise
      filling = 1'b1;
      for (n = 0; n < N_RANDOM; n++) begin
         if (ring_fill == DEPTH) filling = 1'b0;
         else if (ring_fill == 0) filling = 1'b1;
         roll = $urandom_range(99);
         if (roll < 12) begin
            kind = 1'($urandom_range(1));
            len  = LEN_W'($urandom_range(15));
         end else begin
            kind = (roll < 88) ? (filling ? REQ_PUSH : REQ_POP)
                               : (filling ? REQ_POP : REQ_PUSH);
            len  = LEN_W'($urandom_range(BURST_MAX, 1));
            room = (kind == REQ_PUSH) ? DEPTH - int'(ring_fill) : int'(ring_fill);
            // land exactly on full or empty now and then
            if (room > 0 && room < BURST_MAX && $urandom_range(1))
               len = LEN_W'(room);
         end
         // hold off until the block has drained everything once
         if (n == N_RANDOM / 2) begin
            @(negedge clock);
            start <= 1'b0;
            while (due_beats.size() != 0) @(posedge clock);
         end
         gap = (n >= 60 && n < 120) ? 0 : pick_gap();
         send_request(kind, len, {$urandom, $urandom}, gap, 1'b0, '0, '0);
      end

      @(negedge clock);
      start <= 1'b0;
      while (due_beats.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
